@@ rtl/growable_bitmap_allocator_core_macros.svh @@
// Assertion macros used by the checker file of the bitmap allocator.
`ifndef GROWABLE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define GROWABLE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gba_checker: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gba_checker: assertion failed");

`endif

@@ rtl/gba_pkg.sv @@
// Types and constants shared by the bitmap allocator modules.
`default_nettype none

package gba_pkg;

    localparam int OP_W          = 3;
    localparam int BIT_W         = 10;
    localparam int INIT_W        = 11;
    localparam int POS_W         = 10;
    localparam int ST_W          = 2;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 16;
    localparam int BYTE_W        = 8;
    localparam int BITS_PER_BYTE = 8;
    localparam int BYTE_SHIFT    = 3;

    localparam logic [BYTE_W-1:0] BYTE_ONES     = 8'hFF;
    localparam logic [INIT_W-1:0] INIT_BITS_RST = 11'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_SET     = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_TEST    = 3'd3,
        OP_CLR_ALL = 3'd4,
        OP_SET_ALL = 3'd5,
        OP_FIND    = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NORES = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        WR_ZERO,
        WR_ONES,
        WR_SETBIT,
        WR_CLRBIT,
        WR_FIND
    } wr_sel_t;

    typedef enum logic [1:0] {
        POS_NONE,
        POS_SCAN,
        POS_BIT
    } pos_sel_t;

    typedef struct packed {
        logic     load;
        logic     init_regs;
        logic     k_clr;
        logic     k_from_used;
        logic     k_inc;
        logic     g_start;
        logic     g_step;
        logic     grow_commit;
        logic     bit_from_used;
        logic     mem_rd;
        logic     mem_wr;
        logic     addr_k;
        wr_sel_t  wr_sel;
        logic     res_set;
        status_t  res_status;
        logic     res_test;
        pos_sel_t res_pos;
        logic     out_load;
    } gba_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            init_bad;
        logic            over_cap;
        logic            in_used;
        logic            legal_ok;
        logic            used_full;
        logic            k_done_used;
        logic            k_done_grow;
        logic            grow_done;
        logic            grow_fail;
        logic            byte_full;
        logic            past_cap;
    } gba_stat_t;

endpackage

`default_nettype wire

@@ rtl/growable_bitmap_allocator_core.sv @@
// Top level of the growable bitmap allocator.
// Requests enter on the s_ stream channel, one item per operation, and each
// one gives exactly one result item on the m_ stream channel. The cfg channel
// writes the size that the init operation applies. It is always ready; the
// user must write it only while no request is in flight; nothing enforces it.
// One request is worked on at a time. A set, clear or test inside the used
// bytes reads its map byte (SET or CT_RD), writes it if needed and sets the
// result (SET_WR or CT_WR); EMIT loads the output register and IDLE takes the
// next item. Find and set reads each byte it scans (SCAN_RD) and checks it
// (SCAN_CHK). Init, clear all and set all write one map byte per cycle over
// the used bytes. Growth first steps a running multiple of the byte count up
// past the target byte, one add per cycle, then zero-fills one new byte per
// cycle. These sweeps are set by the byte map memory's single write port.
// After reset the block clears the first used bytes of the map (eight bytes,
// or the whole map when it is smaller), holding s_tready low meanwhile.
// The result register lets the next request be taken while a result waits;
// when m_tready stays low the block finishes that request and then waits.
`default_nettype none

module growable_bitmap_allocator_core #(
    parameter int CAPACITY_BITS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [gba_pkg::INIT_W-1:0]           cfg_data,      // initial_bits
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [gba_pkg::IN_TDATA_W-1:0]       s_tdata,       // op, bit_index
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [gba_pkg::OUT_TDATA_W-1:0]           m_tdata        // status, is_set,
                                                                     // found_position
);

    import gba_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - ST_W - 1 - POS_W;

    gba_cmd_t         cmd;
    gba_stat_t        stat;
    logic [ST_W-1:0]  out_status;
    logic             out_is_set;
    logic [POS_W-1:0] out_pos;

    assign cfg_ready = 1'b1;

    gba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gba_dp #(
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .in_op      (s_tdata[OP_W-1:0]),
        .in_bit     (s_tdata[OP_W+BIT_W-1:OP_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (out_status),
        .out_is_set (out_is_set),
        .out_pos    (out_pos)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_pos, out_is_set, out_status};

endmodule

`default_nettype wire

@@ rtl/gba_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/gba_ctrl.sv @@
// Controller state machine of the bitmap allocator.
`default_nettype none

module gba_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [gba_pkg::OP_W-1:0]  in_op,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output gba_pkg::gba_cmd_t              cmd,
    input  wire gba_pkg::gba_stat_t        stat
);

    import gba_pkg::*;

    typedef enum logic [3:0] {
        RST_CLR,
        IDLE,
        INIT,
        FILL_Z,
        FILL_O,
        SET,
        GROW_CALC,
        GROW_FILL,
        SET_WR,
        CT_RD,
        CT_WR,
        SCAN_RD,
        SCAN_CHK,
        EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            RST_CLR:
            begin
                if (stat.k_done_used)
                begin
                    state_next = IDLE;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.addr_k = 1'b1;
                    cmd.wr_sel = WR_ZERO;
                    cmd.k_inc  = 1'b1;
                end
            end
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    cmd.k_clr = 1'b1;
                    unique case (in_op)
                        OP_INIT:    state_next = INIT;
                        OP_SET:     state_next = SET;
                        OP_CLEAR:   state_next = CT_RD;
                        OP_TEST:    state_next = CT_RD;
                        OP_CLR_ALL: state_next = FILL_Z;
                        OP_SET_ALL: state_next = FILL_O;
                        OP_FIND:    state_next = SCAN_RD;
                        default:
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_BAD;
                            state_next     = EMIT;
                        end
                    endcase
                end
            end
            INIT:
            begin
                if (stat.init_bad)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.init_regs = 1'b1;
                    state_next    = FILL_Z;
                end
            end
            FILL_Z, FILL_O:
            begin
                if (stat.k_done_used)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.addr_k = 1'b1;
                    cmd.wr_sel = (state_reg == FILL_O) ? WR_ONES : WR_ZERO;
                    cmd.k_inc  = 1'b1;
                end
            end
            SET:
            begin
                priority if (stat.over_cap)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = EMIT;
                end
                else if (stat.in_used)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = SET_WR;
                end
                else if (stat.used_full)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NORES;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.g_start = 1'b1;
                    state_next  = GROW_CALC;
                end
            end
            GROW_CALC:
            begin
                if (!stat.grow_done)
                begin
                    cmd.g_step = 1'b1;
                end
                else if (stat.grow_fail)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NORES;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.k_from_used = 1'b1;
                    state_next      = GROW_FILL;
                end
            end
            GROW_FILL:
            begin
                if (stat.k_done_grow)
                begin
                    cmd.grow_commit = 1'b1;
                    cmd.mem_rd      = 1'b1;
                    state_next      = SET_WR;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.addr_k = 1'b1;
                    cmd.wr_sel = WR_ZERO;
                    cmd.k_inc  = 1'b1;
                end
            end
            SET_WR:
            begin
                cmd.mem_wr     = 1'b1;
                cmd.wr_sel     = WR_SETBIT;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_pos    = (stat.op == OP_FIND) ? POS_BIT : POS_NONE;
                state_next     = EMIT;
            end
            CT_RD:
            begin
                if (!stat.legal_ok)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = CT_WR;
                end
            end
            CT_WR:
            begin
                cmd.mem_wr     = (stat.op == OP_CLEAR);
                cmd.wr_sel     = WR_CLRBIT;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_test   = (stat.op == OP_TEST);
                state_next     = EMIT;
            end
            SCAN_RD:
            begin
                priority if (!stat.k_done_used)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.addr_k = 1'b1;
                    state_next = SCAN_CHK;
                end
                else if (stat.past_cap)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NORES;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.bit_from_used = 1'b1;
                    state_next        = SET;
                end
            end
            SCAN_CHK:
            begin
                if (stat.byte_full)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = SCAN_RD;
                end
                else
                begin
                    cmd.mem_wr     = 1'b1;
                    cmd.addr_k     = 1'b1;
                    cmd.wr_sel     = WR_FIND;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_pos    = POS_SCAN;
                    state_next     = EMIT;
                end
            end
            EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RST_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gba_dp.sv @@
// Datapath of the bitmap allocator: map memory, counters, bounds and result registers.
`default_nettype none

module gba_dp #(
    parameter int CAPACITY_BITS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gba_pkg::INIT_W-1:0]  cfg_data,
    input  wire logic [gba_pkg::OP_W-1:0]    in_op,
    input  wire logic [gba_pkg::BIT_W-1:0]   in_bit,
    input  wire gba_pkg::gba_cmd_t           cmd,
    output gba_pkg::gba_stat_t               stat,
    output logic [gba_pkg::ST_W-1:0]         out_status,
    output logic                             out_is_set,
    output logic [gba_pkg::POS_W-1:0]        out_pos
);

    import gba_pkg::*;

    localparam int CAP_BYTES = (CAPACITY_BITS + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
    localparam int AW        = (CAP_BYTES > 1) ? $clog2(CAP_BYTES) : 1;
    localparam int UMAX      = (CAP_BYTES > 8) ? CAP_BYTES : 8;
    localparam int UW        = $clog2(UMAX + 1);
    localparam int GW        = $clog2(2 * UMAX + 1);
    localparam int BITW      = ($clog2(CAPACITY_BITS) > BIT_W) ? $clog2(CAPACITY_BITS) : BIT_W;
    localparam int LLW       = ($clog2(CAPACITY_BITS + 1) > INIT_W) ?
                               $clog2(CAPACITY_BITS + 1) : INIT_W;
    localparam int CW0       = (GW > LLW) ? GW : LLW;
    localparam int CW        = ((CW0 > BITW) ? CW0 : BITW) + 1;
    localparam int USED_RST  = (int'(INIT_BITS_RST) + BITS_PER_BYTE - 1) / BITS_PER_BYTE;

    logic [INIT_W-1:0] init_bits_reg, init_bits_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [LLW-1:0]    legal_reg, legal_next;
    logic [UW-1:0]     k_reg, k_next;
    logic [GW-1:0]     g_reg, g_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [BITW-1:0]   bit_reg, bit_next;
    logic              rd_oob_reg, rd_oob_next;
    status_t           res_status_reg, res_status_next;
    logic              res_is_set_reg, res_is_set_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    status_t           out_status_reg, out_status_next;
    logic              out_is_set_reg, out_is_set_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;

    logic [CW-1:0]     bit_x, idx_x, used_x, legal_x, k_x, g_x;
    logic [CW-1:0]     cap_bits_x, cap_bytes_x, lim_x, gcap_x, addr_x;
    logic              addr_oob;
    logic [BYTE_W-1:0] ram_rdata, rbyte, wbyte, bit_mask;
    logic [2:0]        zero_off;

    assign bit_x       = CW'(bit_reg);
    assign idx_x       = CW'(bit_reg >> BYTE_SHIFT);
    assign used_x      = CW'(used_reg);
    assign legal_x     = CW'(legal_reg);
    assign k_x         = CW'(k_reg);
    assign g_x         = CW'(g_reg);
    assign cap_bits_x  = CW'(CAPACITY_BITS);
    assign cap_bytes_x = CW'(CAP_BYTES);
    assign lim_x       = (used_x < cap_bytes_x) ? used_x : cap_bytes_x;
    assign gcap_x      = (g_x < cap_bytes_x) ? g_x : cap_bytes_x;
    assign addr_x      = cmd.addr_k ? k_x : idx_x;
    assign addr_oob    = (addr_x >= cap_bytes_x);
    assign rbyte       = rd_oob_reg ? '0 : ram_rdata;
    assign bit_mask    = BYTE_W'(1) << bit_reg[2:0];

    assign stat.op          = op_reg;
    assign stat.init_bad    = (init_bits_reg == '0) || (CW'(init_bits_reg) > cap_bits_x);
    assign stat.over_cap    = (bit_x >= cap_bits_x);
    assign stat.in_used     = (idx_x < used_x);
    assign stat.legal_ok    = (bit_x < legal_x) && (idx_x < used_x);
    assign stat.used_full   = (used_x >= cap_bytes_x) || (used_reg == '0);
    assign stat.k_done_used = (k_x >= lim_x);
    assign stat.k_done_grow = (k_x >= gcap_x);
    assign stat.grow_done   = (g_x > idx_x) || (g_x >= cap_bytes_x);
    assign stat.grow_fail   = (idx_x >= gcap_x);
    assign stat.byte_full   = (rbyte == BYTE_ONES);
    assign stat.past_cap    = ((used_x << BYTE_SHIFT) >= cap_bits_x);

    always_comb
    begin
        zero_off = 3'd0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!rbyte[i])
            begin
                zero_off = 3'(i);
            end
        end
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_ZERO:   wbyte = '0;
            WR_ONES:   wbyte = BYTE_ONES;
            WR_SETBIT: wbyte = rbyte | bit_mask;
            WR_CLRBIT: wbyte = rbyte & ~bit_mask;
            WR_FIND:   wbyte = rbyte | (rbyte + BYTE_W'(1));
            default:   wbyte = '0;
        endcase
    end

    gba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (cmd.mem_wr && !addr_oob),
        .waddr (addr_x[AW-1:0]),
        .wdata (wbyte),
        .re    (cmd.mem_rd),
        .raddr (addr_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        init_bits_next = init_bits_reg;
        used_next      = used_reg;
        legal_next     = legal_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        op_next        = op_reg;
        bit_next       = bit_reg;
        rd_oob_next    = rd_oob_reg;
        if (cfg_we)
        begin
            init_bits_next = cfg_data;
        end
        if (cmd.load)
        begin
            op_next  = in_op;
            bit_next = BITW'(in_bit);
        end
        if (cmd.bit_from_used)
        begin
            bit_next = BITW'(used_x << BYTE_SHIFT);
        end
        if (cmd.init_regs)
        begin
            used_next  = UW'((CW'(init_bits_reg) + CW'(BITS_PER_BYTE - 1)) >> BYTE_SHIFT);
            legal_next = LLW'(init_bits_reg);
        end
        if (cmd.grow_commit)
        begin
            used_next  = UW'(gcap_x);
            legal_next = LLW'(bit_x + CW'(1));
        end
        priority if (cmd.k_clr)
        begin
            k_next = '0;
        end
        else if (cmd.k_from_used)
        begin
            k_next = used_reg;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + UW'(1);
        end
        if (cmd.g_start)
        begin
            g_next = GW'(used_reg);
        end
        else if (cmd.g_step)
        begin
            g_next = g_reg + GW'(used_reg);
        end
        if (cmd.mem_rd)
        begin
            rd_oob_next = addr_oob;
        end
    end

    always_comb
    begin
        res_status_next = res_status_reg;
        res_is_set_next = res_is_set_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_is_set_next = out_is_set_reg;
        out_pos_next    = out_pos_reg;
        if (cmd.res_set)
        begin
            res_status_next = cmd.res_status;
            res_is_set_next = cmd.res_test & rbyte[bit_reg[2:0]];
            unique case (cmd.res_pos)
                POS_SCAN: res_pos_next = POS_W'((k_x << BYTE_SHIFT) | CW'(zero_off));
                POS_BIT:  res_pos_next = POS_W'(bit_reg);
                default:  res_pos_next = '0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_next = res_status_reg;
            out_is_set_next = res_is_set_reg;
            out_pos_next    = res_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_bits_reg <= INIT_BITS_RST;
            used_reg      <= UW'(USED_RST);
            legal_reg     <= LLW'(INIT_BITS_RST);
            k_reg         <= '0;
            g_reg         <= '0;
            rd_oob_reg    <= 1'b0;
        end
        else
        begin
            init_bits_reg <= init_bits_next;
            used_reg      <= used_next;
            legal_reg     <= legal_next;
            k_reg         <= k_next;
            g_reg         <= g_next;
            rd_oob_reg    <= rd_oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_is_set_reg <= res_is_set_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_is_set_reg <= out_is_set_next;
        out_pos_reg    <= out_pos_next;
    end

    assign out_status = out_status_reg;
    assign out_is_set = out_is_set_reg;
    assign out_pos    = out_pos_reg;

endmodule

`default_nettype wire

@@ rtl/gba_checker.sv @@
// Port-level checker for the bitmap allocator, bound to the top level.
`default_nettype none

`include "growable_bitmap_allocator_core_macros.svh"

module gba_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [gba_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    import gba_pkg::*;

    logic [ST_W-1:0]  rsp_status;
    logic             rsp_is_set;
    logic [POS_W-1:0] rsp_pos;
    logic             rsp_known;
    logic             rsp_clean;

    assign rsp_status = m_tdata[ST_W-1:0];
    assign rsp_is_set = m_tdata[ST_W];
    assign rsp_pos    = m_tdata[ST_W+POS_W:ST_W+1];
    assign rsp_known  = (rsp_status == ST_OK) || (rsp_status == ST_BAD) ||
                        (rsp_status == ST_NORES);
    assign rsp_clean  = (rsp_status == ST_OK) || (!rsp_is_set && rsp_pos == '0);

    // A request holds the block, so a new item is never taken right after one.
    `GBA_ASSERT_NEXT(a_accept_drops_ready, s_tvalid && s_tready, !s_tready)

    // Status is a known code, and test and position data come only with success.
    `GBA_ASSERT_IMPL(a_result_consistent, m_tvalid, rsp_known && rsp_clean)

    `GBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    `GBA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind growable_bitmap_allocator_core gba_checker u_gba_checker (.*);

`default_nettype wire

@@ sim/growable_bitmap_allocator_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the growable bitmap allocator core.
module growable_bitmap_allocator_core_test;
    import gba_pkg::*;

    localparam int CAP_BITS     = 1024;
    localparam int CAP_BYTES    = CAP_BITS / BITS_PER_BYTE;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int MAX_SHOWN    = 10;
    localparam int IDLE_PAUSE   = 20;
    localparam int PHASE_ITEMS  = 124;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BIT_W-1:0] bit_index;
    } alloc_req_t;

    typedef struct packed {
        status_t          status;
        logic             is_set;
        logic [POS_W-1:0] found;
    } alloc_rsp_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [INIT_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    wire                    cfg_ready;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    growable_bitmap_allocator_core #(
        .CAPACITY_BITS(CAP_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the allocator state.
    logic [BYTE_W-1:0] map_mem [CAP_BYTES];
    int unsigned       used_bytes_m;
    int unsigned       legal_limit_m;
    int unsigned       size_reg_m;

    alloc_req_t pending_reqs[$];
    alloc_rsp_t pending_results[$];

    int  cycles         = 0;
    int  requests_taken = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  settings_used  = 1;
    int  grew_count     = 0;
    int  nores_count    = 0;
    int  bad_count      = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic status_t grow_and_mark(int unsigned bnum);
        int unsigned idx;
        int unsigned grown;
        int unsigned k;
        if (bnum >= CAP_BITS)
            return ST_BAD;
        idx = bnum / BITS_PER_BYTE;
        if (idx >= used_bytes_m)
        begin
            if (used_bytes_m >= CAP_BYTES || used_bytes_m == 0)
                return ST_NORES;
            grown = (idx / used_bytes_m + 1) * used_bytes_m;
            if (grown > CAP_BYTES)
                grown = CAP_BYTES;
            if (idx >= grown)
                return ST_NORES;
            for (k = used_bytes_m; k < grown; k++)
                map_mem[k] = '0;
            used_bytes_m  = grown;
            legal_limit_m = bnum + 1;
            grew_count++;
        end
        map_mem[idx][bnum % BITS_PER_BYTE] = 1'b1;
        return ST_OK;
    endfunction

    function automatic alloc_rsp_t apply_request(alloc_req_t r);
        alloc_rsp_t        rsp;
        int unsigned       k;
        int unsigned       idx;
        int unsigned       off;
        int unsigned       p;
        logic [BYTE_W-1:0] v;
        rsp.status = ST_OK;
        rsp.is_set = 1'b0;
        rsp.found  = '0;
        case (r.op)
            OP_INIT:
                if (size_reg_m == 0 || size_reg_m > CAP_BITS)
                    rsp.status = ST_BAD;
                else
                begin
                    legal_limit_m = size_reg_m;
                    used_bytes_m  = (size_reg_m + 7) / BITS_PER_BYTE;
                    for (k = 0; k < CAP_BYTES; k++)
                        map_mem[k] = '0;
                end
            OP_SET:
                rsp.status = grow_and_mark(r.bit_index);
            OP_CLEAR, OP_TEST:
                if (r.bit_index >= legal_limit_m || r.bit_index / BITS_PER_BYTE >= used_bytes_m)
                    rsp.status = ST_BAD;
                else
                begin
                    idx = r.bit_index / BITS_PER_BYTE;
                    off = r.bit_index % BITS_PER_BYTE;
                    if (r.op == OP_CLEAR)
                        map_mem[idx][off] = 1'b0;
                    else
                        rsp.is_set = map_mem[idx][off];
                end
            OP_CLR_ALL, OP_SET_ALL:
                for (k = 0; k < used_bytes_m && k < CAP_BYTES; k++)
                    map_mem[k] = (r.op == OP_CLR_ALL) ? '0 : BYTE_ONES;
            OP_FIND:
            begin
                k = 0;
                while (k < used_bytes_m && k < CAP_BYTES && map_mem[k] == BYTE_ONES)
                    k++;
                if (k >= used_bytes_m)
                begin
                    p = used_bytes_m * BITS_PER_BYTE;
                    if (p >= CAP_BITS)
                        rsp.status = ST_NORES;
                    else
                    begin
                        rsp.status = grow_and_mark(p);
                        if (rsp.status == ST_OK)
                            rsp.found = POS_W'(p);
                    end
                end
                else
                begin
                    v   = map_mem[k];
                    off = 0;
                    while (off < 7 && v[off])
                        off++;
                    map_mem[k] = v | (v + 8'd1);
                    rsp.found  = POS_W'(k * BITS_PER_BYTE + off);
                end
            end
            default:
                rsp.status = ST_BAD;
        endcase
        if (rsp.status == ST_NORES)
            nores_count++;
        else if (rsp.status == ST_BAD)
            bad_count++;
        return rsp;
    endfunction

    function automatic alloc_req_t random_request();
        alloc_req_t  r;
        int unsigned sel;
        int unsigned spread;
        sel = $urandom_range(0, 99);
        if (sel < 18)
            r.op = OP_SET;
        else if (sel < 33)
            r.op = OP_CLEAR;
        else if (sel < 53)
            r.op = OP_TEST;
        else if (sel < 78)
            r.op = OP_FIND;
        else if (sel < 84)
            r.op = OP_SET_ALL;
        else if (sel < 90)
            r.op = OP_CLR_ALL;
        else if (sel < 96)
            r.op = OP_INIT;
        else
            r.op = OP_UNUSED;
        spread = $urandom_range(0, 9);
        if (spread < 4)
            r.bit_index = BIT_W'($urandom_range(0, 63));
        else if (spread < 7)
            r.bit_index = BIT_W'($urandom_range(0, 255));
        else
            r.bit_index = BIT_W'($urandom_range(0, CAP_BITS - 1));
        return r;
    endfunction

    // Request side: acceptance feeds the predictor, the driver offers at the falling edge.
    logic offer_taken = 1'b0;
    int   burst_left  = 0;
    int   gap_left    = 0;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            pending_results.push_back(apply_request(pending_reqs.pop_front()));
            requests_taken++;
            offer_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!s_tvalid || offer_taken)
        begin
            offer_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (rst_n && pending_reqs.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_TDATA_W - BIT_W - OP_W){1'b0}},
                             pending_reqs[0].bit_index, pending_reqs[0].op};
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side: the stall pattern changes per window, with two long hold-offs.
    int   rx_mode    = 0;
    int   rx_window  = 0;
    int   hold_left  = 0;
    int   holds_done = 0;
    logic rx_ready;

    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_done < 2 &&
            results_seen >= (holds_done == 0 ? 80 : 450))
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready = 1'b0;
        end
        else
        begin
            if (rx_window == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                rx_window = $urandom_range(20, 80);
            end
            rx_window--;
            case (rx_mode)
                0:       rx_ready = 1'b1;
                1:       rx_ready = 1'($urandom_range(0, 1));
                2:       rx_ready = (cycles % 4 == 0);
                default: rx_ready = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_tready <= rx_ready;
    end

    alloc_rsp_t want;
    logic       have_want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            have_want = (pending_results.size() > 0);
            if (have_want)
                want = pending_results.pop_front();
            if (!have_want || m_tdata[1:0] !== want.status || m_tdata[2] !== want.is_set ||
                m_tdata[12:3] !== want.found)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    if (!have_want)
                        $display("Result %0d arrived with nothing expected: tdata %h",
                                 results_seen, m_tdata);
                    else
                        $display({"Result %0d: expected status %0d is_set %0d pos %0d, ",
                                  "got status %0d is_set %0d pos %0d"},
                                 results_seen, want.status, want.is_set, want.found,
                                 m_tdata[1:0], m_tdata[2], m_tdata[12:3]);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_size(int unsigned v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= INIT_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg_m = v % (1 << INIT_W);
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(logic [OP_W-1:0] op, int unsigned bnum);
        alloc_req_t r;
        r.op        = op;
        r.bit_index = BIT_W'(bnum);
        pending_reqs.push_back(r);
    endtask

    int unsigned phase_sizes [6];

    initial
    begin
        for (int k = 0; k < CAP_BYTES; k++)
            map_mem[k] = '0;
        size_reg_m    = INIT_BITS_RST;
        legal_limit_m = INIT_BITS_RST;
        used_bytes_m  = (INIT_BITS_RST + 7) / BITS_PER_BYTE;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_req(OP_TEST, 0);
        push_req(OP_SET, 0);
        push_req(OP_TEST, 0);
        push_req(OP_CLEAR, 0);
        push_req(OP_TEST, 0);
        push_req(OP_TEST, 63);
        push_req(OP_TEST, 64);
        push_req(OP_CLEAR, 1023);
        push_req(OP_FIND, 0);
        push_req(OP_SET_ALL, 0);
        push_req(OP_FIND, 0);
        push_req(OP_TEST, 64);
        push_req(OP_TEST, 65);
        push_req(OP_SET, 1023);
        push_req(OP_SET_ALL, 0);
        push_req(OP_FIND, 0);
        push_req(OP_SET, 5);
        push_req(OP_CLR_ALL, 0);
        push_req(OP_TEST, 1023);
        push_req(OP_UNUSED, 1023);
        write_size(0);
        push_req(OP_INIT, 0);
        write_size(2047);
        push_req(OP_INIT, 0);
        write_size(1025);
        push_req(OP_INIT, 0);
        write_size(1);
        push_req(OP_INIT, 0);
        push_req(OP_SET, 1023);
        write_size(1024);
        push_req(OP_INIT, 0);
        push_req(OP_TEST, 1023);

        phase_sizes[0] = 64;
        phase_sizes[1] = 1;
        phase_sizes[2] = 1024;
        phase_sizes[3] = $urandom_range(2, 1023);
        phase_sizes[4] = 8;
        phase_sizes[5] = $urandom_range(1, 1024);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_size(phase_sizes[ph]);
            push_req(OP_INIT, 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_request());
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Run covered %0d requests and %0d results over %0d size settings.",
                 requests_taken, results_seen, settings_used);
        $display("The map grew %0d times; %0d requests ran out of room, %0d were rejected.",
                 grew_count, nores_count, bad_count);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ growable_bitmap_allocator_core.f @@
+incdir+rtl
rtl/gba_pkg.sv
rtl/gba_ram.sv
rtl/gba_ctrl.sv
rtl/gba_dp.sv
rtl/growable_bitmap_allocator_core.sv
rtl/gba_checker.sv
sim/growable_bitmap_allocator_core_test.sv
